// ===== hdl/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap frame allocator package
// Sizes, field widths, action codes, status codes and register indexes that
// the allocator, its channels and its bitmap store share.
// ----------------------------------------------------------------------------
package bfa_pkg;

   // Bitmap geometry.
   localparam int MAX_FRAMES = 32768;
   localparam int WORD_BITS  = 32;
   localparam int BM_WORDS   = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_IDX_W = $clog2(BM_WORDS);
   localparam int BIT_IDX_W  = $clog2(WORD_BITS);

   // Field widths.
   localparam int ACTION_W = 2;
   localparam int FRAME_W  = 15;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 16;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 1;

   // Frame limits hold values up to MAX_FRAMES itself.
   localparam int LIMIT_W = $clog2(MAX_FRAMES) + 1;

   // Action codes.
   localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_INIT  = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STS_NOFREE   = 2'd1;
   localparam logic [STATUS_W-1:0] STS_RANGE    = 2'd2;
   localparam logic [STATUS_W-1:0] STS_NOTALLOC = 2'd3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_TOTAL   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_RESERVE = 1'b1;

   // Register reset values.
   localparam logic [CSR_W-1:0] FRAME_TOTAL_RESET   = 16'd32768;
   localparam logic [CSR_W-1:0] FRAME_RESERVE_RESET = 16'd513;

endpackage

// ===== hdl/bfa_if.sv =====
// ----------------------------------------------------------------------------
// Bitmap frame allocator channels
// Valid/ready request and response channels of the allocator.
// ----------------------------------------------------------------------------
interface bfa_req_if;
   import bfa_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [FRAME_W-1:0]  frame_number;

   modport source (output valid, action, frame_number, input ready);
   modport sink   (input valid, action, frame_number, output ready);
endinterface

interface bfa_rsp_if;
   import bfa_pkg::*;

   logic                valid;
   logic                ready;
   logic [FRAME_W-1:0]  granted_frame;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  used_count;

   modport source (output valid, granted_frame, status, used_count, input ready);
   modport sink   (input valid, granted_frame, status, used_count, output ready);
endinterface

// ===== hdl/bfa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hdl/bitmap_frame_allocator.sv =====
// ----------------------------------------------------------------------------
// Bitmap frame allocator
// First-fit page-frame allocator over a bitmap of used bits with a used count.
//
//   Channel   Direction  Handshake     Contents
//   req_chan  in         valid/ready   action, frame_number
//   rsp_chan  out        valid/ready   granted_frame, status, used_count
//   csr_*     in         write enable  frame total (0), frame reserve (1)
//
// One item is worked on at a time; the bitmap RAM port sets the pace.
// Alloc scans words from word 0 up for a free bit below the limit; free reads
// one word and clears the bit if set; init writes all 1024 words, one word
// written per cycle; an unused action or an out-of-range free goes straight
// to the result. After reset a clearing pass writes zero to all 1024 words
// before the first item is accepted. A stalled result holds the next one in
// the result state, and no item is accepted meanwhile.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator (
   input  logic                     clock,
   input  logic                     reset,
   bfa_req_if.sink                  req_chan,
   bfa_rsp_if.source                rsp_chan,
   input  logic                     csr_write_enable,
   input  logic [bfa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bfa_pkg::CSR_W-1:0]     csr_write_data
);
   import bfa_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ALLOC,
      ST_FREE,
      ST_INIT,
      ST_RESULT
   } state_type;

   state_type               state_ff, state_in;
   logic [WORD_IDX_W-1:0]   word_ff, word_in;
   logic [FRAME_W-1:0]      frame_ff, frame_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [CSR_W-1:0]        total_ff, total_in;
   logic [CSR_W-1:0]        reserved_ff, reserved_in;
   logic [FRAME_W-1:0]      pend_granted_ff, pend_granted_in;
   logic [STATUS_W-1:0]     pend_status_ff, pend_status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]      rsp_granted_ff, rsp_granted_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   logic                    ram_we;
   logic [WORD_IDX_W-1:0]   ram_waddr;
   logic [WORD_BITS-1:0]    ram_wdata;
   logic                    ram_re;
   logic [WORD_IDX_W-1:0]   ram_raddr;
   logic [WORD_BITS-1:0]    ram_rdata;

   logic                    req_accept;
   logic [LIMIT_W-1:0]      limit;
   logic [LIMIT_W-1:0]      reserve_n;
   logic [LIMIT_W-BIT_IDX_W-1:0] init_full;
   logic [BIT_IDX_W-1:0]    init_rest;
   logic [WORD_BITS-1:0]    init_mask;
   logic [LIMIT_W-1:0]      scan_base;
   logic [LIMIT_W-1:0]      scan_span;
   logic [WORD_BITS-1:0]    scan_mask;
   logic [WORD_BITS-1:0]    scan_avail;
   logic [WORD_BITS-1:0]    scan_onehot;
   logic [BIT_IDX_W-1:0]    scan_bit;
   logic [COUNT_W-1:0]      count_inc;
   logic [COUNT_W-1:0]      count_dec;

   bfa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (BM_WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign req_accept             = req_chan.valid && (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.granted_frame = rsp_granted_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.used_count    = rsp_count_ff;

   // Effective frame limit and clamped reserve.
   always_comb begin
      if (total_ff < LIMIT_W'(MAX_FRAMES)) begin
         limit = LIMIT_W'(total_ff);
      end else begin
         limit = LIMIT_W'(MAX_FRAMES);
      end
      if (LIMIT_W'(reserved_ff) < limit) begin
         reserve_n = LIMIT_W'(reserved_ff);
      end else begin
         reserve_n = limit;
      end
      init_full = reserve_n[LIMIT_W-1:BIT_IDX_W];
      init_rest = reserve_n[BIT_IDX_W-1:0];
      for (int i = 0; i < WORD_BITS; i++) begin
         init_mask[i] = (BIT_IDX_W'(i) < init_rest);
      end
   end

   // Scan of the word that the RAM returns: valid bits below the limit and
   // lowest free bit.
   always_comb begin
      scan_base = LIMIT_W'({word_ff, {BIT_IDX_W{1'b0}}});
      scan_span = limit - scan_base;
      for (int i = 0; i < WORD_BITS; i++) begin
         scan_mask[i] = (LIMIT_W'(i) < scan_span);
      end
      scan_avail  = ~ram_rdata & scan_mask;
      scan_onehot = scan_avail & (~scan_avail + WORD_BITS'(1));
      scan_bit    = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (scan_onehot[i]) begin
            scan_bit = scan_bit | BIT_IDX_W'(i);
         end
      end
   end

   // Saturating count steps.
   assign count_inc = (count_ff == {COUNT_W{1'b1}}) ? count_ff : count_ff + COUNT_W'(1);
   assign count_dec = (count_ff == '0) ? count_ff : count_ff - COUNT_W'(1);

   // Sequencer next state, RAM control and configuration writes.
   always_comb begin
      state_in        = state_ff;
      word_in         = word_ff;
      frame_in        = frame_ff;
      count_in        = count_ff;
      total_in        = total_ff;
      reserved_in     = reserved_ff;
      pend_granted_in = pend_granted_ff;
      pend_status_in  = pend_status_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_granted_in  = rsp_granted_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_count_in    = rsp_count_ff;
      ram_we          = 1'b0;
      ram_waddr       = word_ff;
      ram_wdata       = '0;
      ram_re          = 1'b0;
      ram_raddr       = '0;

      if (csr_write_enable) begin
         case (csr_index)
            REG_FRAME_TOTAL:   total_in    = csr_write_data;
            REG_FRAME_RESERVE: reserved_in = csr_write_data;
            default:           ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_we  = 1'b1;
            word_in = word_ff + WORD_IDX_W'(1);
            if (word_ff == WORD_IDX_W'(BM_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               frame_in        = req_chan.frame_number;
               word_in         = '0;
               pend_granted_in = '0;
               pend_status_in  = STS_OK;
               case (req_chan.action)
                  ACT_ALLOC: begin
                     ram_re   = 1'b1;
                     state_in = ST_ALLOC;
                  end
                  ACT_FREE: begin
                     if (LIMIT_W'(req_chan.frame_number) >= limit) begin
                        pend_status_in = STS_RANGE;
                        state_in       = ST_RESULT;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = req_chan.frame_number[FRAME_W-1:BIT_IDX_W];
                        state_in  = ST_FREE;
                     end
                  end
                  ACT_INIT: begin
                     state_in = ST_INIT;
                  end
                  default: begin
                     state_in = ST_RESULT;
                  end
               endcase
            end
         end
         ST_ALLOC: begin
            if (scan_base >= limit) begin
               pend_status_in = STS_NOFREE;
               state_in       = ST_RESULT;
            end else if (scan_avail != '0) begin
               ram_we          = 1'b1;
               ram_wdata       = ram_rdata | scan_onehot;
               count_in        = count_inc;
               pend_granted_in = FRAME_W'(scan_base | LIMIT_W'(scan_bit));
               state_in        = ST_RESULT;
            end else if (word_ff == WORD_IDX_W'(BM_WORDS - 1)) begin
               pend_status_in = STS_NOFREE;
               state_in       = ST_RESULT;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = word_ff + WORD_IDX_W'(1);
               word_in   = word_ff + WORD_IDX_W'(1);
            end
         end
         ST_FREE: begin
            if (!ram_rdata[frame_ff[BIT_IDX_W-1:0]]) begin
               pend_status_in = STS_NOTALLOC;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = frame_ff[FRAME_W-1:BIT_IDX_W];
               ram_wdata = ram_rdata & ~(WORD_BITS'(1) << frame_ff[BIT_IDX_W-1:0]);
               count_in  = count_dec;
            end
            state_in = ST_RESULT;
         end
         ST_INIT: begin
            // Full words below the reserve, one partial word, zero above.
            ram_we = 1'b1;
            if ((LIMIT_W-BIT_IDX_W)'(word_ff) < init_full) begin
               ram_wdata = '1;
            end else if ((LIMIT_W-BIT_IDX_W)'(word_ff) == init_full) begin
               ram_wdata = init_mask;
            end
            word_in = word_ff + WORD_IDX_W'(1);
            if (word_ff == WORD_IDX_W'(BM_WORDS - 1)) begin
               count_in = COUNT_W'(reserve_n);
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = pend_granted_ff;
               rsp_status_in  = pend_status_ff;
               rsp_count_in   = count_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, counters, configuration and output registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         word_ff      <= '0;
         count_ff     <= '0;
         total_ff     <= FRAME_TOTAL_RESET;
         reserved_ff  <= FRAME_RESERVE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         reserved_ff  <= reserved_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      frame_ff        <= frame_in;
      pend_granted_ff <= pend_granted_in;
      pend_status_ff  <= pend_status_in;
      rsp_granted_ff  <= rsp_granted_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_count_ff    <= rsp_count_in;
   end

endmodule
